// File: rtl/core/wmbd_pkg.sv
// Shared types, constants and the bytewise CRC-16 step for the wM-Bus deframer.
// No dependencies; the classifier, top level, checker and testbench import this package.
`default_nettype none

package wmbd_pkg;

   // Frame geometry
   localparam int unsigned BLK1A_TOTAL = 12;   // format A block 1: 10 data + 2 check
   localparam int unsigned BLK1A_DATA  = 10;
   localparam int unsigned BLKA_STRIDE = 18;   // format A data block: 16 data + 2 check
   localparam int unsigned BLKA_DATA   = 16;
   localparam int unsigned LA_HEADER   = 9;
   localparam int unsigned LB_MIN      = 12;
   localparam int unsigned BLK12B_MAX  = 126;
   localparam int unsigned BLK3B_START = 128;
   localparam int unsigned LB_BLK3     = 130;
   localparam int unsigned POS_MAX     = 511;

   localparam logic [15:0] CRC_POLY_RESET = 16'h3D65;
   localparam logic [15:0] CRC_XOR_RESET  = 16'hFFFF;

   // Configuration register indexes
   localparam logic CSR_CRC_POLY      = 1'b0;
   localparam logic CSR_CRC_FINAL_XOR = 1'b1;

   // Frame status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

   typedef enum logic [1:0] {
      ROLE_SKIP,
      ROLE_DATA,
      ROLE_CHK_HI,
      ROLE_CHK_LO
   } role_type;

   // What the classifier tells the datapath about the current byte
   typedef struct packed {
      role_type role;
      logic     later_block;   // byte belongs to a block whose CRC errors set err_later
      logic     block_start;   // first data byte of a block: restart the CRC
   } role_info_type;

   // One byte of CRC-16, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/wmbd_channels_if.sv
// Valid/ready channel interfaces for the deframer: byte requests in, results out.
// Depends on nothing; widths follow the fixed byte and status fields.
`default_nettype none

interface wmbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       first_of_frame;
   logic       last_of_frame;
   logic       format_b;

   modport source (output valid, in_byte, first_of_frame, last_of_frame, format_b,
                   input ready);
   modport sink   (input valid, in_byte, first_of_frame, last_of_frame, format_b,
                   output ready);
endinterface

interface wmbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_byte_valid;
   logic       frame_done;
   logic [1:0] frame_status;

   modport source (output valid, out_byte, out_byte_valid, frame_done, frame_status,
                   input ready);
   modport sink   (input valid, out_byte, out_byte_valid, frame_done, frame_status,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/core/wmbd_byte_role.sv
// Byte classifier: decides whether a frame byte is data, a check byte or dropped.
// Depends on wmbd_pkg for the frame geometry and the role types.
`default_nettype none

module wmbd_byte_role (
   input  logic [8:0]              pos,        // index of this byte in the frame
   input  logic [7:0]              len,        // length field L
   input  logic                    fmt_b,
   input  logic [4:0]              a_off,      // format A: offset inside the 18-byte stride
   input  logic [4:0]              a_blk,      // format A: data block number from 0
   output wmbd_pkg::role_info_type info
);
   import wmbd_pkg::*;

   logic [7:0] a_d;
   logic [4:0] a_nb;
   logic [8:0] a_rem;
   logic [4:0] a_size;
   logic [3:0] a_idx;
   logic [6:0] b_bs;
   logic [9:0] pos_p1;

   always_comb begin
      a_d    = len - 8'(LA_HEADER);
      a_nb   = 5'(({1'b0, a_d} + 9'd15) >> 4);
      a_rem  = {1'b0, a_d} - {1'b0, a_blk[3:0], 4'd0};
      a_size = (a_rem > 9'(BLKA_DATA)) ? 5'(BLKA_DATA) : a_rem[4:0];
      a_idx  = a_blk[3:0] + 4'd1;   // wraps to zero for the sixteenth data block
      b_bs   = (len > 8'(BLK12B_MAX + 1)) ? 7'(BLK12B_MAX) : 7'(len - 8'd1);
      pos_p1 = {1'b0, pos} + 10'd1;

      info = '{role: ROLE_SKIP, later_block: 1'b0, block_start: 1'b0};

      if (!fmt_b) begin
         if (pos < 9'(BLK1A_TOTAL)) begin
            info.block_start = (pos == 9'd0);
            if (pos < 9'(BLK1A_DATA)) begin
               info.role = ROLE_DATA;
            end else if (pos == 9'(BLK1A_DATA)) begin
               info.role = ROLE_CHK_HI;
            end else begin
               info.role = ROLE_CHK_LO;
            end
         end else if (len >= 8'(LA_HEADER) && a_blk < a_nb) begin
            info.later_block = (a_idx != 4'd0);
            info.block_start = (a_off == 5'd0);
            if (a_off < a_size) begin
               info.role = ROLE_DATA;
            end else if (a_off == a_size) begin
               info.role = ROLE_CHK_HI;
            end else if ({1'b0, a_off} == {1'b0, a_size} + 6'd1) begin
               info.role = ROLE_CHK_LO;
            end
         end
      end else begin
         if (len < 8'(LB_MIN)) begin
            info.block_start = 1'b1;
            if (pos == 9'd0) begin
               info.role = ROLE_DATA;
            end
         end else if (pos <= {2'b00, b_bs} + 9'd1) begin
            info.block_start = (pos == 9'd0);
            if (pos < {2'b00, b_bs}) begin
               info.role = ROLE_DATA;
            end else if (pos == {2'b00, b_bs}) begin
               info.role = ROLE_CHK_HI;
            end else begin
               info.role = ROLE_CHK_LO;
            end
         end else if (len > 8'(LB_BLK3) && pos >= 9'(BLK3B_START)
                      && pos <= {1'b0, len}) begin
            info.later_block = 1'b1;
            info.block_start = (pos == 9'(BLK3B_START));
            if (pos_p1 < {2'b00, len}) begin
               info.role = ROLE_DATA;
            end else if (pos_p1 == {2'b00, len}) begin
               info.role = ROLE_CHK_HI;
            end else begin
               info.role = ROLE_CHK_LO;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/wmbus_block_crc_deframer.sv
// Wireless M-Bus format A/B deframer top level: CRC check, check-byte removal, status.
// Depends on wmbd_pkg, wmbd_channels_if and wmbd_byte_role.
//
//   channel  direction  payload                                              flow
//   req_if   in         in_byte, first_of_frame, last_of_frame, format_b     valid/ready
//   rsp_if   out        out_byte, out_byte_valid, frame_done, frame_status   valid/ready
//   csr_*    in         csr_index, csr_wdata (write only)                    csr_we
//
// Each byte is classified, fed through one bytewise CRC-16 step and checked in the
// cycle it is taken; the result is then registered in the output register.
// Throughput is one byte per cycle while the output does not stall, set by the
// single-byte CRC step and the counter update between the frame state and the output register.
// The input is ready whenever the output register is empty or being drained,
// so a stalled consumer only holds the stream once a result is waiting.
// Synchronous reset closes any open frame, empties the output register and
// restores the CRC polynomial and final XOR to their defaults.
`default_nettype none

module wmbus_block_crc_deframer (
   input  logic              clock,
   input  logic              reset,
   wmbd_req_if.sink          req_if,
   wmbd_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import wmbd_pkg::*;

   // Configuration registers
   logic [15:0] crc_poly_ff;
   logic [15:0] crc_xor_ff;

   // Frame state
   logic        frame_open_ff, frame_open_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic        fmt_ff, fmt_in;
   logic [4:0]  a_off_ff, a_off_in;
   logic [4:0]  a_blk_ff, a_blk_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic        err_first_ff, err_first_in;
   logic        err_later_ff, err_later_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_bvalid_ff, rsp_bvalid_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // Values seen by this byte: a first byte restarts the frame in place
   logic        first;
   logic        open_eff;
   logic [8:0]  pos_eff;
   logic [7:0]  len_eff;
   logic        fmt_eff;
   logic [4:0]  a_off_eff;
   logic [4:0]  a_blk_eff;
   logic [15:0] crc_eff;
   logic [7:0]  crc_hi_eff;
   logic        err_first_eff;
   logic        err_later_eff;

   logic          req_xfer;
   logic          has_result;
   role_info_type info;
   logic [7:0]    a_d;
   logic [4:0]    a_nb;
   logic [9:0]    count;
   logic [9:0]    a_need;
   logic [1:0]    status;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer     = req_if.valid && req_if.ready;

   assign first         = req_if.first_of_frame;
   assign open_eff      = first || frame_open_ff;
   assign pos_eff       = first ? 9'd0 : pos_ff;
   assign len_eff       = first ? req_if.in_byte : len_ff;
   assign fmt_eff       = first ? req_if.format_b : fmt_ff;
   assign a_off_eff     = first ? 5'd0 : a_off_ff;
   assign a_blk_eff     = first ? 5'd0 : a_blk_ff;
   assign crc_eff       = first ? 16'd0 : crc_ff;
   assign crc_hi_eff    = first ? 8'd0 : crc_hi_ff;
   assign err_first_eff = first ? 1'b0 : err_first_ff;
   assign err_later_eff = first ? 1'b0 : err_later_ff;

   wmbd_byte_role u_role (
      .pos   (pos_eff),
      .len   (len_eff),
      .fmt_b (fmt_eff),
      .a_off (a_off_eff),
      .a_blk (a_blk_eff),
      .info  (info)
   );

   // Per-byte datapath: CRC, check compare, counters and the result
   always_comb begin
      frame_open_in = frame_open_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      fmt_in        = fmt_ff;
      a_off_in      = a_off_ff;
      a_blk_in      = a_blk_ff;
      crc_in        = crc_ff;
      crc_hi_in     = crc_hi_ff;
      err_first_in  = err_first_ff;
      err_later_in  = err_later_ff;
      rsp_byte_in   = 8'd0;
      rsp_bvalid_in = 1'b0;
      rsp_done_in   = 1'b0;
      rsp_status_in = STATUS_OK;
      has_result    = 1'b0;

      a_d    = len_eff - 8'(LA_HEADER);
      a_nb   = 5'(({1'b0, a_d} + 9'd15) >> 4);
      count  = {1'b0, pos_eff} + 10'd1;
      a_need = 10'(BLK1A_TOTAL) + {2'b00, a_d} + {4'd0, a_nb, 1'b0};
      status = STATUS_OK;

      if (open_eff) begin
         len_in       = len_eff;
         fmt_in       = fmt_eff;
         crc_in       = crc_eff;
         crc_hi_in    = crc_hi_eff;
         err_first_in = err_first_eff;
         err_later_in = err_later_eff;

         case (info.role)
            ROLE_DATA: begin
               crc_in        = crc_feed(info.block_start ? 16'd0 : crc_eff,
                                        req_if.in_byte, crc_poly_ff);
               rsp_bvalid_in = 1'b1;
               rsp_byte_in   = req_if.in_byte;
               if (fmt_eff && pos_eff == 9'd0) begin
                  // rewrite L to drop the check bytes of blocks 1+2 (and 3)
                  rsp_byte_in = req_if.in_byte
                                - ((len_eff > 8'(LB_BLK3)) ? 8'd4 : 8'd2);
               end
            end
            ROLE_CHK_HI: begin
               crc_hi_in = req_if.in_byte;
            end
            ROLE_CHK_LO: begin
               if ((crc_eff ^ crc_xor_ff) != {crc_hi_eff, req_if.in_byte}) begin
                  if (info.later_block) begin
                     err_later_in = 1'b1;
                  end else begin
                     err_first_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         if (!fmt_eff) begin
            if (err_first_in) begin
               status = STATUS_CRC_ERROR;
            end else if (len_eff < 8'(LA_HEADER) || count < a_need) begin
               status = STATUS_TOO_SHORT;
            end else if (err_later_in) begin
               status = STATUS_CRC_ERROR;
            end
         end else begin
            if (len_eff < 8'(LB_MIN) || count < {2'b00, len_eff} + 10'd1) begin
               status = STATUS_TOO_SHORT;
            end else if (err_first_in || err_later_in) begin
               status = STATUS_CRC_ERROR;
            end
         end

         if (req_if.last_of_frame) begin
            rsp_done_in   = 1'b1;
            rsp_status_in = status;
         end
         frame_open_in = !req_if.last_of_frame;
         has_result    = rsp_bvalid_in || req_if.last_of_frame;

         // advance position; hold everything once it saturates
         pos_in   = pos_eff;
         a_off_in = a_off_eff;
         a_blk_in = a_blk_eff;
         if (pos_eff < 9'(POS_MAX)) begin
            pos_in = pos_eff + 9'd1;
            if (pos_eff >= 9'(BLK1A_TOTAL)) begin
               if (a_off_eff == 5'(BLKA_STRIDE - 1)) begin
                  a_off_in = 5'd0;
                  a_blk_in = a_blk_eff + 5'd1;
               end else begin
                  a_off_in = a_off_eff + 5'd1;
               end
            end
         end
      end

      // Output register: load a new result, or drop the old one once taken
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (req_xfer && has_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff <= CRC_POLY_RESET;
         crc_xor_ff  <= CRC_XOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CRC_POLY:      crc_poly_ff <= csr_wdata;
            CSR_CRC_FINAL_XOR: crc_xor_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         pos_ff        <= 9'd0;
         len_ff        <= 8'd0;
         fmt_ff        <= 1'b0;
         a_off_ff      <= 5'd0;
         a_blk_ff      <= 5'd0;
         crc_ff        <= 16'd0;
         crc_hi_ff     <= 8'd0;
         err_first_ff  <= 1'b0;
         err_later_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            frame_open_ff <= frame_open_in;
            pos_ff        <= pos_in;
            len_ff        <= len_in;
            fmt_ff        <= fmt_in;
            a_off_ff      <= a_off_in;
            a_blk_ff      <= a_blk_in;
            crc_ff        <= crc_in;
            crc_hi_ff     <= crc_hi_in;
            err_first_ff  <= err_first_in;
            err_later_ff  <= err_later_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: hold while a stalled result waits
   always_ff @(posedge clock) begin
      if (req_xfer && has_result) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_bvalid_ff <= rsp_bvalid_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_byte       = rsp_byte_ff;
   assign rsp_if.out_byte_valid = rsp_bvalid_ff;
   assign rsp_if.frame_done     = rsp_done_ff;
   assign rsp_if.frame_status   = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/core/wmbd_checker.sv
// Port-level checks for the deframer, bound onto the top level.
// Depends on wmbd_pkg for the status codes.
`default_nettype none

module wmbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       out_byte_valid,
   input logic       frame_done,
   input logic [1:0] frame_status
);
   import wmbd_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte)
         && $stable(out_byte_valid) && $stable(frame_done) && $stable(frame_status))
      else $error("result changed while stalled");

   // the input only stalls behind a waiting result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a pending result");

   // a fresh result needs a transfer on the input in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an input transfer");

   // every result carries a byte or closes a frame, with a legal status
   a_rsp_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_byte_valid || frame_done)
         && (frame_status == STATUS_OK || frame_status == STATUS_CRC_ERROR
             || frame_status == STATUS_TOO_SHORT)
         && (frame_done || frame_status == STATUS_OK))
      else $error("malformed result");

endmodule

bind wmbus_block_crc_deframer wmbd_checker u_wmbd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .out_byte       (rsp_if.out_byte),
   .out_byte_valid (rsp_if.out_byte_valid),
   .frame_done     (rsp_if.frame_done),
   .frame_status   (rsp_if.frame_status)
);

`default_nettype wire

// File: sim/deframer_checker.sv
// Scoreboard for the wM-Bus A/B deframer: watches both channels and the CSR port,
// predicts each result from an independent model of the framing and CRC rules.
// Depends on wmbd_pkg and wmbd_channels_if.
`default_nettype none

module deframer_checker (
   input  logic        clock,
   input  logic        reset,
   wmbd_req_if         req_mon,
   wmbd_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          awaited_count
);
   import wmbd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       done;
      logic [1:0] status;
   } frame_result_type;

   frame_result_type awaited[$];

   // Configuration copy
   logic [15:0] poly_q;
   logic [15:0] xor_q;

   // Frame state
   logic [8:0]  pos_q;
   logic [7:0]  len_q;
   logic        fmt_b_q;
   logic [15:0] crc_q;
   logic [7:0]  chk_hi_q;
   logic        err_first_q;
   logic        err_later_q;
   logic        open_q;

   // Bitwise form of the CRC-16 step: feedback is the top CRC bit XOR the data bit.
   function automatic logic [15:0] next_crc(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = c[15] ^ data[k];
         c  = {c[14:0], 1'b0} ^ (fb ? poly_q : 16'h0000);
      end
      return c;
   endfunction

   function automatic role_type byte_role(input int unsigned p, output logic later_blk,
                                          output logic restart_crc);
      int unsigned L, d, nb, n, off, span;
      L           = len_q;
      later_blk   = 1'b0;
      restart_crc = 1'b0;
      if (!fmt_b_q) begin
         if (p < BLK1A_TOTAL) begin
            restart_crc = (p == 0);
            if (p < BLK1A_DATA) return ROLE_DATA;
            return (p == BLK1A_DATA) ? ROLE_CHK_HI : ROLE_CHK_LO;
         end
         if (L < LA_HEADER) return ROLE_SKIP;
         d   = L - LA_HEADER;
         nb  = (d + BLKA_DATA - 1) / BLKA_DATA;
         n   = (p - BLK1A_TOTAL) / BLKA_STRIDE;
         off = (p - BLK1A_TOTAL) % BLKA_STRIDE;
         if (n >= nb) return ROLE_SKIP;
         span = d - BLKA_DATA * n;
         if (span > BLKA_DATA) span = BLKA_DATA;
         // The block index is four bits wide: the sixteenth data block wraps to
         // zero and its CRC errors land in the first-block flag.
         later_blk   = ((n + 1) % 16) != 0;
         restart_crc = (off == 0);
         if (off < span) return ROLE_DATA;
         if (off == span) return ROLE_CHK_HI;
         if (off == span + 1) return ROLE_CHK_LO;
         return ROLE_SKIP;
      end
      if (L < LB_MIN) begin
         restart_crc = 1'b1;
         return (p == 0) ? ROLE_DATA : ROLE_SKIP;
      end
      span = (L - 1 > BLK12B_MAX) ? BLK12B_MAX : L - 1;
      if (p <= span + 1) begin
         restart_crc = (p == 0);
         if (p < span) return ROLE_DATA;
         return (p == span) ? ROLE_CHK_HI : ROLE_CHK_LO;
      end
      if (L > LB_BLK3 && p >= BLK3B_START && p <= L) begin
         later_blk   = 1'b1;
         restart_crc = (p == BLK3B_START);
         if (p + 1 < L) return ROLE_DATA;
         return (p + 1 == L) ? ROLE_CHK_HI : ROLE_CHK_LO;
      end
      return ROLE_SKIP;
   endfunction

   function automatic logic [1:0] status_at(input int unsigned count);
      int unsigned L, d, need;
      L = len_q;
      if (!fmt_b_q) begin
         need = BLK1A_TOTAL;
         if (L >= LA_HEADER) begin
            d    = L - LA_HEADER;
            need = need + d + 2 * ((d + BLKA_DATA - 1) / BLKA_DATA);
         end
         if (err_first_q) return STATUS_CRC_ERROR;
         if (L < LA_HEADER || count < need) return STATUS_TOO_SHORT;
         return err_later_q ? STATUS_CRC_ERROR : STATUS_OK;
      end
      if (L < LB_MIN || count < L + 1) return STATUS_TOO_SHORT;
      if (err_first_q || err_later_q) return STATUS_CRC_ERROR;
      return STATUS_OK;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic first, input logic last,
                               input logic fb);
      frame_result_type r;
      role_type         role;
      logic             later_blk;
      logic             restart_crc;
      int unsigned      p;
      r = '0;
      if (first) begin
         open_q      = 1'b1;
         pos_q       = '0;
         len_q       = b;
         fmt_b_q     = fb;
         err_first_q = 1'b0;
         err_later_q = 1'b0;
         crc_q       = '0;
         chk_hi_q    = '0;
      end
      if (!open_q) return;
      p    = pos_q;
      role = byte_role(p, later_blk, restart_crc);
      case (role)
         ROLE_DATA: begin
            if (restart_crc) crc_q = '0;
            crc_q        = next_crc(crc_q, b);
            r.byte_valid = 1'b1;
            r.data       = b;
            if (fmt_b_q && p == 0) r.data = b - ((len_q > LB_BLK3) ? 8'd4 : 8'd2);
         end
         ROLE_CHK_HI: chk_hi_q = b;
         ROLE_CHK_LO: begin
            if ((crc_q ^ xor_q) != {chk_hi_q, b}) begin
               if (later_blk) err_later_q = 1'b1;
               else err_first_q = 1'b1;
            end
         end
         default: ;
      endcase
      if (last) begin
         r.done   = 1'b1;
         r.status = status_at(p + 1);
         open_q   = 1'b0;
      end
      if (pos_q != 9'(POS_MAX)) pos_q = pos_q + 9'd1;
      if (r.byte_valid || r.done) awaited.insert(awaited.size(), r);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] deframer mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin : watch
      frame_result_type want;
      if (reset) begin
         poly_q         = CRC_POLY_RESET;
         xor_q          = CRC_XOR_RESET;
         pos_q          = '0;
         len_q          = '0;
         fmt_b_q        = 1'b0;
         crc_q          = '0;
         chk_hi_q       = '0;
         err_first_q    = 1'b0;
         err_later_q    = 1'b0;
         open_q         = 1'b0;
         mismatch_count = 0;
         awaited.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h valid %0b done %0b status %0d",
                                         rsp_mon.out_byte, rsp_mon.out_byte_valid,
                                         rsp_mon.frame_done, rsp_mon.frame_status));
            end else begin
               want = awaited.pop_front();
               if (rsp_mon.out_byte !== want.data)
                  report_mismatch($sformatf("out_byte expected %02h got %02h",
                                            want.data, rsp_mon.out_byte));
               if (rsp_mon.out_byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("out_byte_valid expected %0b got %0b",
                                            want.byte_valid, rsp_mon.out_byte_valid));
               if (rsp_mon.frame_done !== want.done)
                  report_mismatch($sformatf("frame_done expected %0b got %0b",
                                            want.done, rsp_mon.frame_done));
               if (rsp_mon.frame_status !== want.status)
                  report_mismatch($sformatf("frame_status expected %0d got %0d",
                                            want.status, rsp_mon.frame_status));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            deframe_byte(req_mon.in_byte, req_mon.first_of_frame, req_mon.last_of_frame,
                         req_mon.format_b);
         if (csr_we === 1'b1) begin
            if (csr_index == CSR_CRC_POLY) poly_q = csr_wdata;
            else xor_q = csr_wdata;
         end
      end
      awaited_count = awaited.size();
   end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Top of the deframer testbench: clock, reset, CSR writes and frame stimulus.
// Builds format A/B frames with good or damaged CRCs and gives the verdict.
// Depends on wmbd_pkg, wmbd_channels_if, the deframer RTL and deframer_checker.
`default_nettype none

module testbench;
   import wmbd_pkg::*;

   localparam int          CLOCK_PERIOD = 12;
   localparam int          RESET_CYCLES = 4;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off for back-pressure
   localparam int          CSR_SETTLE   = 4;     // covers the result register
   localparam int          DRAIN_CYCLES = 16;
   localparam int unsigned PHASE_ITEMS  = 40;    // random bytes per phase, after the directed frames
   localparam int unsigned LONG_FRAME   = 520;   // past the 511 byte position ceiling

   // What is done to a well-formed frame before it goes out
   typedef enum {
      FLAW_NONE,
      FLAW_CORRUPT,        // flip one bit anywhere
      FLAW_CORRUPT_TAIL,   // flip one bit in the closing bytes
      FLAW_CORRUPT_SHORT,  // flip one bit in the first block, then cut the frame
      FLAW_TRUNCATE,       // drop bytes from the end
      FLAW_PAD,            // trailing bytes after the last check
      FLAW_OVERLONG,       // pad far past the byte position ceiling
      FLAW_ABANDON         // never mark the last byte; the next frame restarts
   } frame_flaw_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   int          mismatch_count;
   int          awaited_count;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_requests;
   int unsigned frame_items;
   logic [15:0] cur_poly;
   logic [15:0] cur_xor;
   logic [7:0]  frame_bytes[$];

   wmbd_req_if req_ch ();
   wmbd_rsp_if rsp_ch ();

   wmbus_block_crc_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deframer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: end the run if anything hangs
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: stall at random, and serve long hold-off requests from the stimulus.
   // The hold is counted down here so the sender keeps offering transfers meanwhile.
   initial begin : receiver
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Write one CSR once the block has gone quiet. Called at a falling edge.
   task automatic write_csr(input logic idx, input logic [15:0] data);
      while (awaited_count != 0) @(negedge clock);
      // bytes without a result may still sit in the pipeline: give them time
      repeat (CSR_SETTLE) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_CRC_POLY) cur_poly = data;
      else cur_xor = data;
   endtask

   // Offer one byte and hold it until the block takes it. Called and left at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic fb);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.in_byte        = b;
      req_ch.first_of_frame = first;
      req_ch.last_of_frame  = last;
      req_ch.format_b       = fb;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Add one byte at the end of the frame being built
   task automatic append_byte(input logic [7:0] b);
      frame_bytes.insert(frame_bytes.size(), b);
   endtask

   // Append the two check bytes, high byte first
   task automatic push_check(input logic [15:0] crc);
      logic [15:0] chk;
      chk = crc ^ cur_xor;
      append_byte(chk[15:8]);
      append_byte(chk[7:0]);
   endtask

   // Build a well-formed frame with valid CRCs under the current CSR settings
   task automatic build_frame(input logic fb, input logic [7:0] len);
      logic [15:0] crc;
      logic [7:0]  b;
      int unsigned head, remain, chunk, want, i;
      frame_bytes.delete();
      if (fb && len < LB_MIN) begin
         // short format B: only the length byte means anything, the rest is filler
         append_byte(len);
         repeat ($urandom_range(13)) append_byte(8'($urandom));
         return;
      end
      // first block: length byte plus header, 10 bytes in A, up to 126 in B
      if (fb) head = (len - 1 > BLK12B_MAX) ? BLK12B_MAX : len - 1;
      else head = BLK1A_DATA;
      crc = '0;
      for (i = 0; i < head; i++) begin
         b = (i == 0) ? len : 8'($urandom);
         append_byte(b);
         crc = crc_feed(crc, b, cur_poly);
      end
      push_check(crc);
      if (!fb) begin
         remain = (len >= LA_HEADER) ? len - LA_HEADER : 0;
         while (remain > 0) begin
            chunk = (remain > BLKA_DATA) ? BLKA_DATA : remain;
            crc   = '0;
            for (i = 0; i < chunk; i++) begin
               b = 8'($urandom);
               append_byte(b);
               crc = crc_feed(crc, b, cur_poly);
            end
            push_check(crc);
            remain = remain - chunk;
         end
      end else begin
         // fill up to block 3, or to L+1 bytes when there is none
         want = (len > LB_BLK3) ? BLK3B_START : len + 1;
         while (frame_bytes.size() < want) append_byte(8'($urandom));
         if (len > LB_BLK3) begin
            crc = '0;
            for (i = 0; i < len - BLK3B_START - 1; i++) begin
               b = 8'($urandom);
               append_byte(b);
               crc = crc_feed(crc, b, cur_poly);
            end
            push_check(crc);
         end
      end
   endtask

   task automatic send_frame(input logic fb, input logic [7:0] len, input frame_flaw_type flaw);
      int unsigned n, k;
      build_frame(fb, len);
      n = frame_bytes.size();
      case (flaw)
         FLAW_CORRUPT: begin
            k = $urandom_range(n - 1);
            frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(7));
         end
         FLAW_CORRUPT_TAIL: begin
            k = (n > 3) ? n - 1 - $urandom_range(2) : n - 1;
            frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(7));
         end
         FLAW_CORRUPT_SHORT: begin
            if (n > 2) begin
               k = $urandom_range(1, (n > 10) ? 9 : n - 1);
               frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(7));
               repeat ($urandom_range(1, n - k - 1 + 1)) void'(frame_bytes.pop_back());
            end
         end
         FLAW_TRUNCATE: begin
            if (n > 1) repeat ($urandom_range(1, n - 1)) void'(frame_bytes.pop_back());
         end
         FLAW_PAD: repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
         FLAW_OVERLONG: begin
            while (frame_bytes.size() < LONG_FRAME) append_byte(8'($urandom));
         end
         default: ;
      endcase
      n = frame_bytes.size();
      // format_b only counts on the first byte: toggle it freely elsewhere
      for (k = 0; k < n; k++)
         send_byte(frame_bytes[k], k == 0, (k == n - 1) && (flaw != FLAW_ABANDON),
                   (k == 0) ? fb : 1'($urandom));
      frame_items = frame_items + n;
   endtask

   // Bytes while no frame is open: the block must drop them
   task automatic send_noise();
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom));
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned    start, pick;
      logic           fb;
      logic [7:0]     len;
      frame_flaw_type flaw;
      start = frame_items;
      while (frame_items - start < target) begin
         fb   = 1'($urandom);
         pick = $urandom_range(99);
         // mostly short frames keep the run fast; a few long ones reach block 3
         if (pick < 70) len = 8'(fb ? $urandom_range(12, 40) : $urandom_range(9, 40));
         else if (pick < 80) len = 8'($urandom_range(0, 11));
         else if (pick < 95) len = 8'($urandom_range(41, 130));
         else len = 8'($urandom_range(131, 255));
         pick = $urandom_range(99);
         if (pick < 55) flaw = FLAW_NONE;
         else if (pick < 65) flaw = FLAW_CORRUPT;
         else if (pick < 72) flaw = FLAW_CORRUPT_TAIL;
         else if (pick < 78) flaw = FLAW_CORRUPT_SHORT;
         else if (pick < 86) flaw = FLAW_TRUNCATE;
         else if (pick < 92) flaw = FLAW_PAD;
         else flaw = FLAW_ABANDON;
         send_frame(fb, len, flaw);
         if (flaw != FLAW_ABANDON && $urandom_range(9) == 0) send_noise();
      end
      // close any abandoned frame before the next CSR change
      send_frame(1'($urandom), 8'd20, FLAW_NONE);
   endtask

   initial begin : stimulus
      req_ch.valid          = 1'b0;
      req_ch.in_byte        = '0;
      req_ch.first_of_frame = 1'b0;
      req_ch.last_of_frame  = 1'b0;
      req_ch.format_b       = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_CRC_POLY;
      csr_wdata      = '0;
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests  = 0;
      frame_items    = 0;
      cur_poly       = CRC_POLY_RESET;
      cur_xor        = CRC_XOR_RESET;

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      write_csr(CSR_CRC_POLY, CRC_POLY_RESET);
      write_csr(CSR_CRC_FINAL_XOR, CRC_XOR_RESET);

      // Directed: block geometry edges in format A
      send_frame(1'b0, 8'd9, FLAW_NONE);            // header only, no data blocks
      send_frame(1'b0, 8'd25, FLAW_NONE);           // one full data block
      send_frame(1'b0, 8'd26, FLAW_NONE);           // one full, one single-byte block
      send_frame(1'b0, 8'd8, FLAW_NONE);            // length below header: too short
      send_frame(1'b0, 8'd0, FLAW_NONE);
      send_frame(1'b0, 8'd255, FLAW_CORRUPT_TAIL);  // error in the sixteenth block
      send_frame(1'b0, 8'd40, FLAW_CORRUPT);
      send_frame(1'b0, 8'd40, FLAW_CORRUPT_TAIL);   // data block error only
      send_frame(1'b0, 8'd40, FLAW_CORRUPT_SHORT);  // block 1 error beats too short
      send_frame(1'b0, 8'd40, FLAW_TRUNCATE);
      send_frame(1'b0, 8'd255, FLAW_OVERLONG);      // sixteen good blocks, position saturates
      // Directed: format B, short length, block 3 boundaries
      send_frame(1'b1, 8'd11, FLAW_NONE);
      send_frame(1'b1, 8'd0, FLAW_NONE);
      send_frame(1'b1, 8'd12, FLAW_NONE);
      send_frame(1'b1, 8'd130, FLAW_NONE);          // gap bytes, no block 3
      send_frame(1'b1, 8'd131, FLAW_CORRUPT_TAIL);  // smallest block 3, with an error in it
      send_frame(1'b1, 8'd60, FLAW_CORRUPT_SHORT);  // too short beats crc error
      send_frame(1'b1, 8'd20, FLAW_PAD);            // bytes past the last check
      // Directed: framing corner cases
      send_noise();                                 // nothing open
      send_frame(1'b0, 8'd30, FLAW_ABANDON);        // restart mid-frame
      send_frame(1'b1, 8'd20, FLAW_NONE);
      send_byte(8'hFF, 1'b1, 1'b1, 1'b0);           // length byte is also the last
      send_byte(8'h00, 1'b1, 1'b1, 1'b1);

      // Random phases: each with its own CSR setting and idle pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               write_csr(CSR_CRC_POLY, 16'h0000);
               write_csr(CSR_CRC_FINAL_XOR, 16'hFFFF);
               send_idle_pct  = 67;
               recv_stall_pct = 0;
            end
            2: begin
               write_csr(CSR_CRC_POLY, 16'hFFFF);
               write_csr(CSR_CRC_FINAL_XOR, 16'h0000);
               send_idle_pct  = 0;
               recv_stall_pct = 67;
            end
            default: begin
               write_csr(CSR_CRC_POLY, 16'($urandom));
               write_csr(CSR_CRC_FINAL_XOR, 16'($urandom));
               send_idle_pct  = 11;
               recv_stall_pct = 11;
            end
         endcase
         if (phase == 0) begin
            // hold off the receiver while bytes keep coming: fill the block and stall it
            @(posedge clock);
            hold_requests++;
            @(negedge clock);
         end
         run_random(PHASE_ITEMS);
      end

      // Drain: wait for every expected result, then give stragglers time to show up
      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
